/* rtl/kbd_rpt_pkg.sv */
// ----------------------------------------------------------------------------
// kbd_rpt_pkg
// Shared types and constants for the keyboard report builder: beat
// payloads, slot sizing and status codes.
// ----------------------------------------------------------------------------
package kbd_rpt_pkg;

   // Number of key slots kept in state
   localparam int unsigned KEY_SLOTS     = 6;
   // First modifier usage code; the modifier range is eight codes long
   localparam int unsigned MODIFIER_BASE = 224;
   localparam int unsigned MODIFIER_CNT  = 8;
   // Key slots carried in the report
   localparam int unsigned REPORT_SLOTS  = 6;
   // Wide enough to hold a slot index and the slot count itself
   localparam int unsigned SLOT_CNT_W    = $clog2(KEY_SLOTS + 1);

   // Step status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef logic [7:0] key_code_type;

   // Input beat: one key event
   typedef struct packed {
      key_code_type key_code;
      logic         key_pressed;
   } req_type;

   // Output beat: whole report plus status
   typedef struct packed {
      logic [7:0]   modifier_bits;
      key_code_type slot_0;
      key_code_type slot_1;
      key_code_type slot_2;
      key_code_type slot_3;
      key_code_type slot_4;
      key_code_type slot_5;
      logic         step_status;
   } rsp_type;

endpackage

/* rtl/keyboard_report_builder.sv */
// ----------------------------------------------------------------------------
// keyboard_report_builder
// Keeps a boot-style keyboard report (modifier byte and key slots) and
// updates it from press and release events, one event per beat.
// ----------------------------------------------------------------------------
// Takes one key event per clock while req_stall is low and presents the full
// report via the input register, then the result register. The slot
// search and left-shift on release are one combinational pass between those
// registers, and the slot state is updated as each event leaves the input
// register, so back-to-back events see each other's effect. A stalled result
// holds the input register; one more event can be taken while the result
// waits. Modifier codes set or clear a modifier bit and always report OK;
// other codes fill the first empty slot on press, or clear the first matching
// slot and close the gap on release, reporting FAIL when nothing fits.
module keyboard_report_builder
   import kbd_rpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Pipeline registers
   logic         in_valid_ff, in_valid_in;
   req_type      in_ff, in_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   // Report state
   logic [7:0]   mods_ff, mods_in;
   key_code_type slots_ff [KEY_SLOTS];
   key_code_type slots_in [KEY_SLOTS];

   logic         advance;
   logic         req_accept;

   // Handshake: input register moves on when the result register is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      in_in       = req_accept ? req_data : in_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Report update for the event in the input register
   always_comb begin
      logic                  is_mod;
      logic [2:0]            mod_sel;
      logic [7:0]            mod_mask;
      logic                  free_found;
      logic [SLOT_CNT_W-1:0] free_idx;
      logic                  hit_found;
      logic [SLOT_CNT_W-1:0] hit_idx;
      logic                  end_found;
      logic [SLOT_CNT_W-1:0] end_idx;
      logic                  status;
      key_code_type          report [REPORT_SLOTS];

      is_mod   = ({1'b0, in_ff.key_code} >= 9'(MODIFIER_BASE)) &&
                 ({1'b0, in_ff.key_code} <  9'(MODIFIER_BASE + MODIFIER_CNT));
      mod_sel  = 3'(in_ff.key_code - 8'(MODIFIER_BASE));
      mod_mask = 8'(1) << mod_sel;

      // First empty slot, for a press
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (!free_found && slots_ff[i] == '0) begin
            free_found = 1'b1;
            free_idx   = SLOT_CNT_W'(i);
         end
      end

      // First matching slot, then first empty slot after it, for a release
      hit_found = 1'b0;
      hit_idx   = '0;
      end_found = 1'b0;
      end_idx   = SLOT_CNT_W'(KEY_SLOTS);
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (hit_found && !end_found && slots_ff[i] == '0) begin
            end_found = 1'b1;
            end_idx   = SLOT_CNT_W'(i);
         end
         if (!hit_found && slots_ff[i] == in_ff.key_code) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_CNT_W'(i);
         end
      end

      mods_in = mods_ff;
      status  = STATUS_OK;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         slots_in[i] = slots_ff[i];
      end

      if (advance) begin
         if (is_mod) begin
            // Modifier event touches only the modifier byte
            if (in_ff.key_pressed) begin
               mods_in = mods_ff | mod_mask;
            end else begin
               mods_in = mods_ff & ~mod_mask;
            end
         end else if (in_ff.key_pressed) begin
            // Press: write into first empty slot
            status = free_found ? STATUS_OK : STATUS_FAIL;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (free_found && free_idx == SLOT_CNT_W'(i)) begin
                  slots_in[i] = in_ff.key_code;
               end
            end
         end else begin
            // Release: clear match, shift following keys left up to the gap
            status = hit_found ? STATUS_OK : STATUS_FAIL;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (hit_found && SLOT_CNT_W'(i) >= hit_idx && SLOT_CNT_W'(i) < end_idx) begin
                  slots_in[i] = '0;
                  if (i + 1 < KEY_SLOTS) begin
                     if (SLOT_CNT_W'(i + 1) < end_idx) begin
                        slots_in[i] = slots_ff[i + 1];
                     end
                  end
               end
            end
         end
      end

      // Report view of the updated state
      for (int j = 0; j < REPORT_SLOTS; j++) begin
         report[j] = '0;
         if (j < KEY_SLOTS) begin
            report[j] = slots_in[j];
         end
      end

      rsp_in               = rsp_ff;
      if (advance) begin
         rsp_in.modifier_bits = mods_in;
         rsp_in.slot_0        = report[0];
         rsp_in.slot_1        = report[1];
         rsp_in.slot_2        = report[2];
         rsp_in.slot_3        = report[3];
         rsp_in.slot_4        = report[4];
         rsp_in.slot_5        = report[5];
         rsp_in.step_status   = status;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mods_ff      <= '0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         mods_ff      <= mods_in;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= slots_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyboard_report_builder. Key events go in as beats
// on the request channel. An in-bench copy of the report state predicts every
// result beat, and each accepted result is checked field by field against
// the oldest prediction. Directed events cover the edge cases: modifiers,
// full slots, releases that miss, code zero and duplicates. A random typing
// stream with idle bursts on both sides follows, then a long result hold-off,
// a drain pause, a second random stream and a burst-free run.
// ----------------------------------------------------------------------------
module tb
   import kbd_rpt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KEY_PRESS   = 1'b1;
   localparam logic KEY_RELEASE = 1'b0;
   // Cycles with no beat on either channel before the run is abandoned
   localparam int   STALL_LIMIT = 2000;
   // Length of the deliberate result hold-off
   localparam int   LONG_HOLD   = 80;
   // Settle time after the last result (input reg + result reg + margin)
   localparam int   TAIL_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   keyboard_report_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Predicted report state
   logic [7:0]   mods_model;
   key_code_type slots_model [KEY_SLOTS];

   rsp_type expected_reports [$];
   int      mismatch_cnt = 0;
   bit      idle_on      = 1'b1;
   bit      hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one key event to the predicted state and return the report
   function automatic rsp_type apply_key_event(req_type ev);
      rsp_type      rpt;
      logic         status;
      logic         hit;
      logic         done;
      logic [7:0]   mod_mask;
      key_code_type shown [REPORT_SLOTS];
      int           i;

      status = STATUS_OK;
      if (ev.key_code >= MODIFIER_BASE && ev.key_code < MODIFIER_BASE + MODIFIER_CNT) begin
         mod_mask = 8'(1 << (ev.key_code - MODIFIER_BASE));
         if (ev.key_pressed)
            mods_model = mods_model | mod_mask;
         else
            mods_model = mods_model & ~mod_mask;
      end else if (ev.key_pressed) begin
         // first empty slot takes the code
         done = 1'b0;
         for (i = 0; i < KEY_SLOTS; i++) begin
            if (!done && slots_model[i] == 8'd0) begin
               slots_model[i] = ev.key_code;
               done = 1'b1;
            end
         end
         status = done ? STATUS_OK : STATUS_FAIL;
      end else begin
         // clear first match, shift the rest left up to the first hole
         hit  = 1'b0;
         done = 1'b0;
         for (i = 0; i < KEY_SLOTS; i++) begin
            if (!done) begin
               if (!hit) begin
                  if (slots_model[i] == ev.key_code) begin
                     slots_model[i] = 8'd0;
                     hit = 1'b1;
                  end
               end else if (slots_model[i] == 8'd0) begin
                  done = 1'b1;
               end else begin
                  slots_model[i-1] = slots_model[i];
                  slots_model[i]   = 8'd0;
               end
            end
         end
         status = hit ? STATUS_OK : STATUS_FAIL;
      end

      for (i = 0; i < REPORT_SLOTS; i++)
         shown[i] = (i < KEY_SLOTS) ? slots_model[i] : 8'd0;
      rpt.modifier_bits = mods_model;
      rpt.slot_0        = shown[0];
      rpt.slot_1        = shown[1];
      rpt.slot_2        = shown[2];
      rpt.slot_3        = shown[3];
      rpt.slot_4        = shown[4];
      rpt.slot_5        = shown[5];
      rpt.step_status   = status;
      return rpt;
   endfunction

   // Offer one event, wait for the beat, queue its predicted report.
   // Called right after a rising edge; leaves valid high on return.
   task automatic send_key(input key_code_type code, input logic pressed);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.key_code    <= code;
      req_data.key_pressed <= pressed;
      do @(posedge clock); while (req_stall);
      expected_reports.push_back(apply_key_event('{key_code: code, key_pressed: pressed}));
   endtask

   // Sender pause until every predicted report has been seen
   task automatic wait_reports_drained();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         mismatch_cnt++;
         if (mismatch_cnt <= 10)
            $display("mismatch: %s expected %h got %h at %0t", name, want, got, $realtime);
      end
   endtask

   // Result side: check each accepted beat against the oldest prediction
   initial begin : report_checker
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected report beat %h at %0t", rsp_data, $realtime);
            end else begin
               want = expected_reports.pop_front();
               check_field("modifier_bits", want.modifier_bits, rsp_data.modifier_bits);
               check_field("slot_0", want.slot_0, rsp_data.slot_0);
               check_field("slot_1", want.slot_1, rsp_data.slot_1);
               check_field("slot_2", want.slot_2, rsp_data.slot_2);
               check_field("slot_3", want.slot_3, rsp_data.slot_3);
               check_field("slot_4", want.slot_4, rsp_data.slot_4);
               check_field("slot_5", want.slot_5, rsp_data.slot_5);
               check_field("step_status", {7'd0, want.step_status},
                           {7'd0, rsp_data.step_status});
            end
         end
      end
   end

   // Result stall: random bursts, or one long hold-off on request
   initial begin : rsp_stall_driver
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: cycles without a beat on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("keyboard_report_builder verification failed");
            $finish;
         end
      end
   end

   // Edge cases in a fixed order
   task automatic test_directed();
      // modifiers at both ends of the range
      send_key(8'(MODIFIER_BASE), KEY_PRESS);
      send_key(8'(MODIFIER_BASE + MODIFIER_CNT - 1), KEY_PRESS);
      send_key(8'(MODIFIER_BASE), KEY_RELEASE);
      send_key(8'(MODIFIER_BASE + MODIFIER_CNT - 1), KEY_RELEASE);
      // code zero press with free slots
      send_key(8'd0, KEY_PRESS);
      // fill all slots, with a duplicate and the top code
      send_key(8'd4, KEY_PRESS);
      send_key(8'd255, KEY_PRESS);
      send_key(8'd4, KEY_PRESS);
      send_key(8'd128, KEY_PRESS);
      send_key(8'd1, KEY_PRESS);
      send_key(8'd2, KEY_PRESS);
      // full: press, zero press and zero release all fail
      send_key(8'd9, KEY_PRESS);
      send_key(8'd0, KEY_PRESS);
      send_key(8'd0, KEY_RELEASE);
      // modifier while full still reports ok
      send_key(8'(MODIFIER_BASE + 1), KEY_PRESS);
      // release first match at slot 0, rest shifts left
      send_key(8'd4, KEY_RELEASE);
      // zero release with a hole present
      send_key(8'd0, KEY_RELEASE);
      // misses, including codes just outside the modifier range
      send_key(8'd77, KEY_RELEASE);
      send_key(8'(MODIFIER_BASE - 1), KEY_RELEASE);
      send_key(8'(MODIFIER_BASE + MODIFIER_CNT), KEY_RELEASE);
      // empty out the slots
      send_key(8'd4, KEY_RELEASE);
      send_key(8'd255, KEY_RELEASE);
      send_key(8'd128, KEY_RELEASE);
      send_key(8'd1, KEY_RELEASE);
      send_key(8'd2, KEY_RELEASE);
   endtask

   // Mostly plausible typing: presses, releases of held keys, modifiers;
   // the rest fully random events
   task automatic test_random_typing(input int count);
      key_code_type code;
      logic         pressed;
      int           held;
      int           pick;
      int           n;
      int           i;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            code    = 8'($urandom_range(1, 255));
            pressed = KEY_PRESS;
         end else if (pick < 70) begin
            held = 0;
            for (i = 0; i < KEY_SLOTS; i++)
               if (slots_model[i] != 8'd0) held++;
            code = 8'($urandom_range(0, 255));
            if (held != 0) begin
               held = $urandom_range(0, held - 1);
               for (i = 0; i < KEY_SLOTS; i++)
                  if (slots_model[i] != 8'd0) begin
                     if (held == 0) code = slots_model[i];
                     held--;
                  end
            end
            pressed = KEY_RELEASE;
         end else if (pick < 85) begin
            code    = 8'(MODIFIER_BASE + $urandom_range(0, MODIFIER_CNT - 1));
            pressed = 1'($urandom_range(0, 1));
         end else begin
            code    = 8'($urandom_range(0, 255));
            pressed = 1'($urandom_range(0, 1));
         end
         send_key(code, pressed);
      end
   endtask

   // Long result hold-off while events keep coming, so the input backs up
   task automatic test_result_holdoff();
      bit saved;
      saved        = idle_on;
      idle_on      = 1'b0;
      hold_request = 1'b1;
      test_random_typing(30);
      idle_on      = saved;
   endtask

   initial begin : main
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      mods_model = 8'd0;
      foreach (slots_model[i]) slots_model[i] = 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_typing(400);
      test_result_holdoff();
      wait_reports_drained();
      test_random_typing(400);
      idle_on = 1'b0;
      test_random_typing(150);

      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0)
         mismatch_cnt += expected_reports.size();
      if (mismatch_cnt == 0)
         $display("keyboard_report_builder verification clean");
      else
         $display("keyboard_report_builder verification failed");
      $finish;
   end

endmodule
